[rtl/core/ihex_pkg.sv]
package ihex_pkg;

   // ascii characters the parser looks for
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   // line position saturates here
   localparam logic [9:0] POS_MAX = 10'd1023;

   // record field slots, counted in byte pairs after the colon
   localparam logic [8:0] SLOT_COUNT     = 9'd0;
   localparam logic [8:0] SLOT_ADDR_HIGH = 9'd1;
   localparam logic [8:0] SLOT_ADDR_LOW  = 9'd2;
   localparam logic [8:0] SLOT_TYPE      = 9'd3;
   localparam logic [8:0] SLOT_DATA      = 9'd4;

   // record type that loads the extended high address
   localparam logic [7:0] TYPE_EXT_ADDR = 8'd4;

   // result item kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // default depth of the result queue (at least two)
   localparam int RSP_FIFO_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] address_low;
      logic [15:0] address_high;
      logic [7:0]  record_type;
      logic [7:0]  byte_count;
      logic        record_ok;
      logic        last;
   } rsp_item_type;

   // results produced by one character: up to two, first goes out first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } nibble_type;

   // hex digit decode of one character
   function automatic nibble_type decode_nibble(input logic [7:0] c);
      nibble_type n;
      logic [7:0] d;
      n = '0;
      d = '0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0;
         n.is_hex = 1'b1;
         n.value = d[3:0];
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = c - CHAR_UPPER_A + 8'd10;
         n.is_hex = 1'b1;
         n.value = d[3:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = c - CHAR_LOWER_A + 8'd10;
         n.is_hex = 1'b1;
         n.value = d[3:0];
      end
      return n;
   endfunction

endpackage

[rtl/core/ihex_parse.sv]
module ihex_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_char,
   input  logic             in_last,
   output ihex_pkg::push_type push
);
   import ihex_pkg::*;

   logic [9:0]  pos_ff, pos_in;
   logic [3:0]  hold_ff, hold_in;
   logic        pend_ff, pend_in;
   logic [7:0]  sum_ff, sum_in;
   logic        run_open_ff, run_open_in;
   logic        start_ff, start_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] first_two_ff, first_two_in;
   logic [15:0] ext_ff, ext_in;

   nibble_type  nib;
   logic [7:0]  pair_byte;
   logic [9:0]  pos_m1;
   logic [8:0]  slot;
   logic [8:0]  data_idx;
   logic        data_hit;
   logic        rec_ok;
   logic [15:0] status_high;
   rsp_item_type data_item, status_item;

   assign nib = decode_nibble(in_char);
   assign pair_byte = {hold_ff, nib.value};
   assign pos_m1 = pos_ff - 10'd1;
   assign slot = pos_m1[9:1];
   assign data_idx = slot - SLOT_DATA;

   // per character decode and field capture
   always_comb begin
      pos_in = pos_ff;
      hold_in = hold_ff;
      pend_in = pend_ff;
      sum_in = sum_ff;
      run_open_in = run_open_ff;
      start_in = start_ff;
      count_in = count_ff;
      addr_in = addr_ff;
      type_in = type_ff;
      first_two_in = first_two_ff;
      ext_in = ext_ff;
      data_hit = 1'b0;
      rec_ok = 1'b0;
      status_high = '0;

      if (in_valid) begin
         if (pos_ff == 10'd0) begin
            start_in = (in_char == CHAR_COLON);
         end else if (start_ff && run_open_ff) begin
            if (!nib.is_hex) begin
               run_open_in = 1'b0;
            end else if (!pend_ff) begin
               hold_in = nib.value;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               sum_in = sum_ff + pair_byte;
               if (pos_ff < POS_MAX) begin
                  if (slot == SLOT_COUNT) begin
                     count_in = pair_byte;
                  end else if (slot == SLOT_ADDR_HIGH) begin
                     addr_in = {pair_byte, addr_ff[7:0]};
                  end else if (slot == SLOT_ADDR_LOW) begin
                     addr_in = {addr_ff[15:8], pair_byte};
                  end else if (slot == SLOT_TYPE) begin
                     type_in = pair_byte;
                  end else if (data_idx < {1'b0, count_ff}) begin
                     data_hit = 1'b1;
                     if (data_idx == 9'd0) begin
                        first_two_in = {pair_byte, first_two_ff[7:0]};
                     end else if (data_idx == 9'd1) begin
                        first_two_in = {first_two_ff[15:8], pair_byte};
                     end
                  end
               end
            end
         end

         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 10'd1;
         end

         // close of record: check, update high address, clear the line
         if (in_last) begin
            rec_ok = start_in && (sum_in == 8'd0) && !pend_in;
            if (rec_ok) begin
               if (type_in == TYPE_EXT_ADDR) begin
                  ext_in = first_two_in;
               end
               status_high = ext_in;
            end
            pos_in = '0;
            hold_in = '0;
            pend_in = 1'b0;
            sum_in = '0;
            run_open_in = 1'b1;
            start_in = 1'b0;
            count_in = '0;
            addr_in = '0;
            type_in = '0;
            first_two_in = '0;
         end
      end
   end

   // result items built from the fields as they stand after this character
   always_comb begin
      data_item.kind = KIND_DATA;
      data_item.data_byte = pair_byte;
      data_item.byte_index = data_idx[7:0];
      data_item.address_low = addr_ff;
      data_item.address_high = ext_ff;
      data_item.record_type = type_ff;
      data_item.byte_count = count_ff;
      data_item.record_ok = 1'b0;
      data_item.last = 1'b0;

      status_item.kind = KIND_STATUS;
      status_item.data_byte = '0;
      status_item.byte_index = '0;
      status_item.address_low = (pos_ff == 10'd0) ? 16'd0 : addr_ff;
      status_item.address_high = status_high;
      status_item.record_type = type_ff;
      status_item.byte_count = count_ff;
      status_item.record_ok = rec_ok;
      status_item.last = 1'b1;

      // fields written by this same character
      if (in_valid && start_ff && run_open_ff && pend_ff && nib.is_hex &&
          pos_ff != 10'd0 && pos_ff < POS_MAX) begin
         if (slot == SLOT_COUNT) begin
            status_item.byte_count = pair_byte;
         end else if (slot == SLOT_ADDR_HIGH) begin
            status_item.address_low = {pair_byte, addr_ff[7:0]};
         end else if (slot == SLOT_ADDR_LOW) begin
            status_item.address_low = {addr_ff[15:8], pair_byte};
         end else if (slot == SLOT_TYPE) begin
            status_item.record_type = pair_byte;
         end
      end
   end

   // queue push: data first, then status
   always_comb begin
      push.count = 2'd0;
      push.first = data_item;
      push.second = status_item;
      if (in_valid) begin
         if (data_hit && in_last) begin
            push.count = 2'd2;
         end else if (data_hit) begin
            push.count = 2'd1;
         end else if (in_last) begin
            push.count = 2'd1;
            push.first = status_item;
         end
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hold_ff <= '0;
         pend_ff <= 1'b0;
         sum_ff <= '0;
         run_open_ff <= 1'b1;
         start_ff <= 1'b0;
         count_ff <= '0;
         addr_ff <= '0;
         type_ff <= '0;
         first_two_ff <= '0;
         ext_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         hold_ff <= hold_in;
         pend_ff <= pend_in;
         sum_ff <= sum_in;
         run_open_ff <= run_open_in;
         start_ff <= start_in;
         count_ff <= count_in;
         addr_ff <= addr_in;
         type_ff <= type_in;
         first_two_ff <= first_two_in;
         ext_ff <= ext_in;
      end
   end

   // a fresh line carries no partial pair and no checksum
   a_fresh_line: assert property (@(posedge clock) disable iff (reset)
      pos_ff == 10'd0 |-> !pend_ff && sum_ff == 8'd0 && !start_ff)
      else $error("line state not cleared at start of line");

   // without a colon nothing is decoded
   a_no_colon: assert property (@(posedge clock) disable iff (reset)
      !start_ff |-> sum_ff == 8'd0 && !pend_ff && count_ff == 8'd0)
      else $error("decode ran without start colon");

   // data bytes only come after the header pairs of a started line
   a_data_after_header: assert property (@(posedge clock) disable iff (reset)
      data_hit |-> start_ff && pos_ff >= 10'd9)
      else $error("data byte emitted inside header");

endmodule

[rtl/core/ihex_rsp_fifo.sv]
module ihex_rsp_fifo #(
   parameter int DEPTH = ihex_pkg::RSP_FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ihex_pkg::push_type     push,
   input  logic                   pop,
   output logic                   room_for_two,
   output logic                   not_empty,
   output ihex_pkg::rsp_item_type head
);
   import ihex_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   rsp_item_type mem [DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] wr_next1, wr_next2, rd_next;

   // wrapping pointer steps
   assign wr_next1 = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
   assign wr_next2 = (wr_next1 == LAST_SLOT) ? '0 : wr_next1 + 1'b1;
   assign rd_next  = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;

   assign room_for_two = (count_ff <= CW'(DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_next1;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = wr_next2;
      end
      rd_ptr_in = pop ? rd_next : rd_ptr_ff;
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next1] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> ({1'b0, count_ff} + (CW + 1)'(push.count)) <= (CW + 1)'(DEPTH))
      else $error("result queue overflow");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> rd_ptr_ff == wr_ptr_ff)
      else $error("empty queue with pointers apart");

endmodule

[rtl/core/intel_hex_record_parser.sv]
// A character is registered at the input and its result items then go into the result queue.
// Throughput: one character per cycle while req_stall is low; the result side moves one item
// per cycle while rsp_stall is low, so a character closing a record on a data byte yields two items.
// Input stalls only while a character waits and the result queue lacks room for two.
// Reset (synchronous, active high) clears the line state, the queue and the
// kept extended high address.
module intel_hex_record_parser #(
   parameter int RSP_DEPTH = ihex_pkg::RSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_line_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [15:0] rsp_address_low,
   output logic [15:0] rsp_address_high,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_byte_count,
   output logic        rsp_record_ok,
   output logic        rsp_last
);
   import ihex_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_char_ff;
   logic         in_last_ff;
   logic         room_for_two;
   logic         advance;
   logic         pop;
   push_type     push;
   rsp_item_type head;

   // input register: holds while the queue lacks room
   assign advance = in_valid_ff && room_for_two;
   assign req_stall = in_valid_ff && !room_for_two;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_character;
         in_last_ff <= req_line_last;
      end
   end

   ihex_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (advance),
      .in_char  (in_char_ff),
      .in_last  (in_last_ff),
      .push     (push)
   );

   // result queue
   assign pop = rsp_valid && !rsp_stall;

   ihex_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (pop),
      .room_for_two (room_for_two),
      .not_empty    (rsp_valid),
      .head         (head)
   );

   assign rsp_kind = head.kind;
   assign rsp_data_byte = head.data_byte;
   assign rsp_byte_index = head.byte_index;
   assign rsp_address_low = head.address_low;
   assign rsp_address_high = head.address_high;
   assign rsp_record_type = head.record_type;
   assign rsp_byte_count = head.byte_count;
   assign rsp_record_ok = head.record_ok;
   assign rsp_last = head.last;

endmodule

[bench/tb_intel_hex_record_parser.sv]
`timescale 1ns / 100ps

// predicts the parser's result items and checks them in order
class ihex_record_board;

   ihex_pkg::rsp_item_type awaited_results[$];
   int mismatch_count;

   // state of the line being parsed
   logic [9:0]  line_pos;
   logic [3:0]  high_nibble;
   logic [7:0]  checksum;
   bit          hex_open;
   bit          colon_seen;
   bit          half_pending;
   logic [7:0]  count_f;
   logic [15:0] load_addr;
   logic [7:0]  rec_type;
   logic [15:0] first_pair;

   // survives from record to record
   logic [15:0] ext_high;

   static function int hex_value(logic [7:0] c);
      if (c >= ihex_pkg::CHAR_DIGIT_0 && c <= ihex_pkg::CHAR_DIGIT_9) begin
         return int'(c - ihex_pkg::CHAR_DIGIT_0);
      end
      if (c >= ihex_pkg::CHAR_UPPER_A && c <= ihex_pkg::CHAR_UPPER_F) begin
         return 10 + int'(c - ihex_pkg::CHAR_UPPER_A);
      end
      if (c >= ihex_pkg::CHAR_LOWER_A && c <= ihex_pkg::CHAR_LOWER_F) begin
         return 10 + int'(c - ihex_pkg::CHAR_LOWER_A);
      end
      return -1;
   endfunction

   function void clear_line();
      line_pos     = '0;
      high_nibble  = '0;
      checksum     = '0;
      hex_open     = 1'b1;
      colon_seen   = 1'b0;
      half_pending = 1'b0;
      count_f      = '0;
      load_addr    = '0;
      rec_type     = '0;
      first_pair   = '0;
   endfunction

   function void clear_all();
      clear_line();
      ext_high = '0;
      mismatch_count = 0;
      awaited_results.delete();
   endfunction

   // one accepted character: update the line and queue what it yields
   function void take_character(logic [7:0] c, logic line_last);
      ihex_pkg::rsp_item_type item;
      int nib;
      int slot;
      int data_pos;
      logic [7:0] pair_value;
      bit passed;
      if (line_pos == 0) begin
         colon_seen = (c == ihex_pkg::CHAR_COLON);
      end else if (colon_seen && hex_open) begin
         nib = hex_value(c);
         if (nib < 0) begin
            hex_open = 1'b0;
         end else if (!half_pending) begin
            high_nibble = nib[3:0];
            half_pending = 1'b1;
         end else begin
            pair_value = {high_nibble, nib[3:0]};
            half_pending = 1'b0;
            checksum = checksum + pair_value;
            // fields fill only until the position counter saturates
            if (line_pos < ihex_pkg::POS_MAX) begin
               slot = (int'(line_pos) - 1) / 2;
               data_pos = slot - int'(ihex_pkg::SLOT_DATA);
               if (slot == int'(ihex_pkg::SLOT_COUNT)) begin
                  count_f = pair_value;
               end else if (slot == int'(ihex_pkg::SLOT_ADDR_HIGH)) begin
                  load_addr[15:8] = pair_value;
               end else if (slot == int'(ihex_pkg::SLOT_ADDR_LOW)) begin
                  load_addr[7:0] = pair_value;
               end else if (slot == int'(ihex_pkg::SLOT_TYPE)) begin
                  rec_type = pair_value;
               end else if (data_pos < int'(count_f)) begin
                  if (data_pos == 0) first_pair[15:8] = pair_value;
                  if (data_pos == 1) first_pair[7:0] = pair_value;
                  item = '0;
                  item.kind         = ihex_pkg::KIND_DATA;
                  item.data_byte    = pair_value;
                  item.byte_index   = data_pos[7:0];
                  item.address_low  = load_addr;
                  item.address_high = ext_high;
                  item.record_type  = rec_type;
                  item.byte_count   = count_f;
                  awaited_results.push_back(item);
               end
            end
         end
      end
      if (line_pos < ihex_pkg::POS_MAX) line_pos = line_pos + 1'b1;

      // closing character: status item, then a fresh line
      if (line_last) begin
         passed = colon_seen && checksum == 8'd0 && !half_pending;
         if (passed && rec_type == ihex_pkg::TYPE_EXT_ADDR) ext_high = first_pair;
         item = '0;
         item.kind         = ihex_pkg::KIND_STATUS;
         item.address_low  = load_addr;
         item.address_high = passed ? ext_high : 16'd0;
         item.record_type  = rec_type;
         item.byte_count   = count_f;
         item.record_ok    = passed;
         item.last         = 1'b1;
         awaited_results.push_back(item);
         clear_line();
      end
   endfunction

   task flag_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("%0t ns: %s", $realtime, what);
   endtask

   task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
      if (got_v !== want_v) begin
         flag_mismatch($sformatf("field %s got %0h want %0h", name, got_v, want_v));
      end
   endtask

   // one accepted result item against the oldest prediction
   task match_result(ihex_pkg::rsp_item_type got);
      ihex_pkg::rsp_item_type want;
      if (awaited_results.size() == 0) begin
         flag_mismatch($sformatf("result item kind %0d with nothing awaited", got.kind));
         return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("data_byte", got.data_byte, want.data_byte);
      compare_field("byte_index", got.byte_index, want.byte_index);
      compare_field("address_low", got.address_low, want.address_low);
      compare_field("address_high", got.address_high, want.address_high);
      compare_field("record_type", got.record_type, want.record_type);
      compare_field("byte_count", got.byte_count, want.byte_count);
      compare_field("record_ok", got.record_ok, want.record_ok);
      compare_field("last", got.last, want.last);
   endtask

endclass

module tb_intel_hex_record_parser;
   import ihex_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_CHARS    = 1350;
   localparam int QUIET_FROM      = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = '0;
   logic        req_line_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [15:0] rsp_address_low;
   logic [15:0] rsp_address_high;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_byte_count;
   logic        rsp_record_ok;
   logic        rsp_last;

   rsp_item_type seen_rsp;
   ihex_record_board record_board = new;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit hold_off_request = 1'b0;

   // characters of the line about to be sent
   logic [7:0] line_chars[$];

   intel_hex_record_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_character    (req_character),
      .req_line_last    (req_line_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_address_low  (rsp_address_low),
      .rsp_address_high (rsp_address_high),
      .rsp_record_type  (rsp_record_type),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_record_ok    (rsp_record_ok),
      .rsp_last         (rsp_last)
   );

   assign seen_rsp = {rsp_kind, rsp_data_byte, rsp_byte_index, rsp_address_low,
                      rsp_address_high, rsp_record_type, rsp_byte_count,
                      rsp_record_ok, rsp_last};

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            record_board.take_character(req_character, req_line_last);
         end
         if (rsp_valid && !rsp_stall) begin
            record_board.match_result(seen_rsp);
         end
      end
   end

   // result side stalls: random bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off_request = 1'b0;
         end else if (receiver_idle_pct != 0 &&
                      $urandom_range(0, 99) < receiver_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   initial begin
      #15_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] hex_char(logic [3:0] v, bit lower_case);
      if (v < 4'd10) return CHAR_DIGIT_0 + 8'(v);
      return (lower_case ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v) - 8'd10;
   endfunction

   function automatic void append_pair(logic [7:0] b);
      line_chars.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
      line_chars.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do c = 8'($urandom); while (record_board.hex_value(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] pick_non_colon();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CHAR_COLON);
      return c;
   endfunction

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         2: return 12;
         default: return 35;
      endcase
   endfunction

   function automatic void load_text(string s);
      line_chars.delete();
      for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
   endfunction

   // colon, count, address, type, data pairs (fixed fill or random), checksum
   function automatic void build_record(logic [7:0] dcount, int npairs, logic [15:0] addr,
                                        logic [7:0] rtype, bit good_sum, int fill);
      logic [7:0] sum;
      logic [7:0] b;
      line_chars.delete();
      line_chars.push_back(CHAR_COLON);
      sum = dcount + addr[15:8] + addr[7:0] + rtype;
      append_pair(dcount);
      append_pair(addr[15:8]);
      append_pair(addr[7:0]);
      append_pair(rtype);
      for (int i = 0; i < npairs; i++) begin
         b = (fill < 0) ? 8'($urandom) : fill[7:0];
         sum = sum + b;
         append_pair(b);
      end
      b = 8'd0 - sum;
      if (!good_sum) b = b ^ 8'($urandom_range(1, 255));
      append_pair(b);
   endfunction

   // one item on the input channel, held until taken
   task automatic send_char(logic [7:0] c, bit is_last);
      req_valid <= 1'b1;
      req_character <= c;
      req_line_last <= is_last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_chars.size(); i++) begin
         if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         send_char(line_chars[i], i == line_chars.size() - 1);
      end
   endtask

   // random record: mostly well formed, some damaged
   task automatic send_random_record();
      logic [7:0] dcount;
      logic [7:0] rtype;
      int npairs;
      int n;
      if ($urandom_range(0, 19) == 0) begin
         dcount = 8'($urandom_range(17, 255));
      end else begin
         dcount = 8'($urandom_range(0, 16));
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: rtype = 8'd0;
         5, 6: rtype = 8'd1;
         7, 8: begin
            rtype = TYPE_EXT_ADDR;
            if ($urandom_range(0, 3) != 0) dcount = 8'd2;
         end
         default: rtype = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: npairs = int'(dcount) + $urandom_range(1, 3);
         1: npairs = $urandom_range(0, int'(dcount));
         default: npairs = int'(dcount);
      endcase
      if ($urandom_range(0, 29) == 0) begin
         // plain noise line
         line_chars.delete();
         repeat ($urandom_range(1, 8)) line_chars.push_back(8'($urandom));
      end else begin
         build_record(dcount, npairs, 16'($urandom), rtype, $urandom_range(0, 6) != 0, -1);
         case ($urandom_range(0, 19))
            0: void'(line_chars.pop_back());
            1: begin
               n = $urandom_range(1, line_chars.size() - 1);
               repeat (n) void'(line_chars.pop_back());
            end
            2: line_chars.insert($urandom_range(1, line_chars.size() - 1), pick_non_hex());
            3: line_chars[0] = pick_non_colon();
            4: begin
               line_chars.push_back(8'h0D);
               line_chars.push_back(8'h0A);
            end
            5: line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom);
            default: ;
         endcase
      end
      send_line();
   endtask

   initial begin
      int random_chars;
      int next_shuffle;
      int long_lines_sent;
      random_chars = 0;
      next_shuffle = 250;
      long_lines_sent = 0;
      record_board.clear_all();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed lines
      load_text(":");
      send_line();
      line_chars.delete();
      line_chars.push_back(8'hFF);
      send_line();
      load_text("X00000001FF");
      send_line();
      load_text(":00000001FF");
      send_line();
      load_text(":02000004FFFFFC");
      send_line();
      load_text(":0300300002337a1e");
      send_line();
      load_text(":00000004FC");
      send_line();
      load_text(":020000040800F2");
      send_line();
      load_text(":00000001F");
      send_line();
      load_text(":00000001FF\r\n");
      send_line();
      load_text(":0200000012G3456");
      send_line();
      load_text(":0");
      line_chars.push_back(8'h00);
      send_line();
      load_text(":0210000000AB");
      send_line();
      build_record(8'd1, 3, 16'h0000, 8'd0, 1'b1, -1);
      send_line();
      build_record(8'd1, 1, 16'h1234, TYPE_EXT_ADDR, 1'b1, -1);
      send_line();
      build_record(8'd4, 4, 16'h8000, 8'd0, 1'b0, -1);
      send_line();

      // hold the result side off while records keep coming
      hold_off_request = 1'b1;
      repeat (6) begin
         build_record(8'($urandom_range(0, 8)), 4, 16'($urandom), 8'd0, 1'b1, -1);
         send_line();
      end

      // random records with shifting idle rates, quiet at the end
      sender_idle_pct = pick_idle();
      receiver_idle_pct = pick_idle();
      while (random_chars < RANDOM_CHARS) begin
         if (random_chars >= QUIET_FROM) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end else if (random_chars >= next_shuffle) begin
            sender_idle_pct = pick_idle();
            receiver_idle_pct = pick_idle();
            next_shuffle += 250;
         end
         if (long_lines_sent < 1 && random_chars >= 100) begin
            // full byte count, long enough to saturate the position counter
            build_record(8'd255, 520, 16'($urandom), 8'd0, 1'b1, -1);
            send_line();
            random_chars += line_chars.size();
            long_lines_sent++;
         end else begin
            send_random_record();
            random_chars += line_chars.size();
         end
      end
      req_valid <= 1'b0;

      // drain and finish
      while (record_board.awaited_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (record_board.mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ihex_pkg.sv
rtl/core/ihex_parse.sv
rtl/core/ihex_rsp_fifo.sv
rtl/core/intel_hex_record_parser.sv
bench/tb_intel_hex_record_parser.sv
